// ===== hw/rtl/vcdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vcdc_pkg
// Shared types and constants for the voxel capsule domain classifier.
// ----------------------------------------------------------------------------
package vcdc_pkg;

  // default coordinate width (Q16.8 signed)
  localparam int COORD_BITS_DEF = 24;

  localparam int LABEL_BITS   = 16;
  localparam int EDGE_BITS    = 8;
  localparam int OUT_BITS     = 8;
  localparam int NUM_STAGES   = 8;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [EDGE_BITS-1:0] EDGE_LABEL_RST = 8'd2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HEAD_X,
    REG_HEAD_Y,
    REG_HEAD_Z,
    REG_TAIL_X,
    REG_TAIL_Y,
    REG_TAIL_Z,
    REG_RADIUS,
    REG_EDGE_LABEL
  } cfg_reg_t;

  // per-item decision flags, filled in as the item moves down the pipe
  typedef struct packed {
    logic fixed;      // label alone decides the result
    logic fixed_val;  // result when fixed
    logic degen;      // head equals tail
    logic near;       // inside head or tail sphere
    logic seg_ok;     // projection falls on the segment
  } ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/vcdc_diff.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vcdc_diff
// Stage 1: label decode and the three difference vectors h, t and d.
// ----------------------------------------------------------------------------
module vcdc_diff import vcdc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [LABEL_BITS-1:0]        voxel_label,
  input  logic signed [COORD_BITS-1:0] pos [3],
  input  logic signed [COORD_BITS-1:0] head [3],
  input  logic signed [COORD_BITS-1:0] tail [3],
  input  logic [EDGE_BITS-1:0]         edge_label,
  output logic signed [COORD_BITS:0]   h_r [3],
  output logic signed [COORD_BITS:0]   t_r [3],
  output logic signed [COORD_BITS:0]   d_r [3],
  output ctl_t                         ctl_r
);

  localparam int DW = COORD_BITS + 1;

  logic signed [DW-1:0] h_nxt [3];
  logic signed [DW-1:0] t_nxt [3];
  logic signed [DW-1:0] d_nxt [3];
  ctl_t                 ctl_nxt;

  // differences to head, to tail, and the segment direction
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_nxt[i] = DW'(pos[i]) - DW'(head[i]);
      t_nxt[i] = DW'(pos[i]) - DW'(tail[i]);
      d_nxt[i] = DW'(tail[i]) - DW'(head[i]);
    end
  end

  // background is always out, own label always in
  always_comb begin
    ctl_nxt.fixed     = (voxel_label == '0) ||
                        (voxel_label == LABEL_BITS'(edge_label));
    ctl_nxt.fixed_val = (voxel_label != '0);
    ctl_nxt.degen     = (head[0] == tail[0]) && (head[1] == tail[1]) &&
                        (head[2] == tail[2]);
    ctl_nxt.near      = 1'b0;
    ctl_nxt.seg_ok    = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r   <= h_nxt;
      t_r   <= t_nxt;
      d_r   <= d_nxt;
      ctl_r <= ctl_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vcdc_dot.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vcdc_dot
// Stages 2 and 3: the component products, then dot sums, sphere tests,
// projection range test and the cross product components.
// ----------------------------------------------------------------------------
module vcdc_dot import vcdc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic [1:0]                    en,
  input  logic signed [COORD_BITS:0]    h [3],
  input  logic signed [COORD_BITS:0]    t [3],
  input  logic signed [COORD_BITS:0]    d [3],
  input  ctl_t                          ctl,
  input  logic [COORD_BITS-2:0]         radius,
  output logic signed [2*COORD_BITS+1:0] c_r [3],
  output logic [2*COORD_BITS+1:0]       dd_r,
  output logic [2*COORD_BITS-3:0]       rr_r,
  output ctl_t                          ctl_r
);

  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;        // one product
  localparam int SW  = PW + 1;        // sum of three products
  localparam int RRW = 2 * COORD_BITS - 2;

  // stage 2 registers
  logic signed [PW-1:0] hh_r [3];
  logic signed [PW-1:0] tt_r [3];
  logic signed [PW-1:0] dh_r [3];
  logic signed [PW-1:0] dp_r [3];
  logic signed [PW-1:0] xp_r [6];
  logic [RRW-1:0]       rr_a_r;
  ctl_t                 ctl_a_r;

  // stage 3 logic
  logic signed [SW-1:0] hsum;
  logic signed [SW-1:0] tsum;
  logic signed [SW-1:0] ssum;
  logic signed [SW-1:0] dsum;
  logic signed [SW-1:0] rr_s;
  logic signed [PW-1:0] c_nxt [3];
  ctl_t                 ctl_nxt;

  // products: one multiplier deep
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= h[i] * h[i];
        tt_r[i] <= t[i] * t[i];
        dh_r[i] <= d[i] * h[i];
        dp_r[i] <= d[i] * d[i];
      end
      xp_r[0] <= h[1] * d[2];
      xp_r[1] <= h[2] * d[1];
      xp_r[2] <= h[2] * d[0];
      xp_r[3] <= h[0] * d[2];
      xp_r[4] <= h[0] * d[1];
      xp_r[5] <= h[1] * d[0];
      rr_a_r  <= radius * radius;
      ctl_a_r <= ctl;
    end
  end

  // dot sums and the cheap tests
  always_comb begin
    hsum = SW'(hh_r[0]) + SW'(hh_r[1]) + SW'(hh_r[2]);
    tsum = SW'(tt_r[0]) + SW'(tt_r[1]) + SW'(tt_r[2]);
    ssum = SW'(dh_r[0]) + SW'(dh_r[1]) + SW'(dh_r[2]);
    dsum = SW'(dp_r[0]) + SW'(dp_r[1]) + SW'(dp_r[2]);
    rr_s = $signed(SW'(rr_a_r));

    c_nxt[0] = xp_r[0] - xp_r[1];
    c_nxt[1] = xp_r[2] - xp_r[3];
    c_nxt[2] = xp_r[4] - xp_r[5];

    ctl_nxt        = ctl_a_r;
    ctl_nxt.near   = (hsum <= rr_s) || (tsum <= rr_s);
    ctl_nxt.seg_ok = !ctl_a_r.degen && !ssum[SW-1] && (ssum <= dsum);
  end

  // d.d is below 2^PW, so the sign bit drops
  always_ff @(posedge clk) begin
    if (en[1]) begin
      c_r   <= c_nxt;
      dd_r  <= dsum[PW-1:0];
      rr_r  <= rr_a_r;
      ctl_r <= ctl_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vcdc_cross.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vcdc_cross
// Stages 4 to 7: squared length of the cross product and r^2 * d.d,
// built from split partial products.
// ----------------------------------------------------------------------------
module vcdc_cross import vcdc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic [3:0]                     en,
  input  logic signed [2*COORD_BITS+1:0] c [3],
  input  logic [2*COORD_BITS+1:0]        dd,
  input  logic [2*COORD_BITS-3:0]        rr,
  input  ctl_t                           ctl,
  output logic [4*COORD_BITS+3:0]        cc_r,
  output logic [4*COORD_BITS-1:0]        rd_r,
  output ctl_t                           ctl_r
);

  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;          // signed cross component, also d.d
  localparam int CW  = PW - 1;          // magnitude of a cross component
  localparam int LW  = DW;              // low split width
  localparam int CHW = CW - LW;         // high part of a magnitude
  localparam int RRW = 2 * COORD_BITS - 2;
  localparam int RHW = RRW - LW;        // high part of r^2
  localparam int DHW = PW - LW;         // high part of d.d
  localparam int SQW = 2 * CW;          // one squared component
  localparam int CCW = SQW + 2;         // sum of three squares
  localparam int RDW = RRW + PW;        // r^2 * d.d

  // stage 4: magnitudes
  logic [CW-1:0]  ca_nxt [3];
  logic [CW-1:0]  ca_r   [3];
  logic [PW-1:0]  dd4_r;
  logic [RRW-1:0] rr4_r;
  ctl_t           ctl4_r;

  // stage 5: partial products
  logic [2*CHW-1:0]   phh_r [3];
  logic [CHW+LW-1:0]  phl_r [3];
  logic [2*LW-1:0]    pll_r [3];
  logic [RHW+DHW-1:0] qhh_r;
  logic [RHW+LW-1:0]  qhl_r;
  logic [LW+DHW-1:0]  qlh_r;
  logic [2*LW-1:0]    qll_r;
  ctl_t               ctl5_r;

  // stage 6: assembled products
  logic [SQW-1:0] cs_nxt [3];
  logic [SQW-1:0] cs_r   [3];
  logic [RDW-1:0] rd_nxt;
  logic [RDW-1:0] rd6_r;
  ctl_t           ctl6_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ca_nxt[i] = c[i][PW-1] ? CW'(-c[i]) : CW'(c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ca_r   <= ca_nxt;
      dd4_r  <= dd;
      rr4_r  <= rr;
      ctl4_r <= ctl;
    end
  end

  // split each wide operand into high and low parts
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        phh_r[i] <= ca_r[i][CW-1:LW] * ca_r[i][CW-1:LW];
        phl_r[i] <= ca_r[i][CW-1:LW] * ca_r[i][LW-1:0];
        pll_r[i] <= ca_r[i][LW-1:0] * ca_r[i][LW-1:0];
      end
      qhh_r  <= rr4_r[RRW-1:LW] * dd4_r[PW-1:LW];
      qhl_r  <= rr4_r[RRW-1:LW] * dd4_r[LW-1:0];
      qlh_r  <= rr4_r[LW-1:0] * dd4_r[PW-1:LW];
      qll_r  <= rr4_r[LW-1:0] * dd4_r[LW-1:0];
      ctl5_r <= ctl4_r;
    end
  end

  // recombine: a^2 = H^2 << 2L + 2HL << L + L^2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cs_nxt[i] = (SQW'(phh_r[i]) << (2 * LW)) + (SQW'(phl_r[i]) << (LW + 1)) +
                  SQW'(pll_r[i]);
    end
    rd_nxt = (RDW'(qhh_r) << (2 * LW)) + (RDW'(qhl_r) << LW) +
             (RDW'(qlh_r) << LW) + RDW'(qll_r);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      cs_r   <= cs_nxt;
      rd6_r  <= rd_nxt;
      ctl6_r <= ctl5_r;
    end
  end

  // |h x d|^2
  always_ff @(posedge clk) begin
    if (en[3]) begin
      cc_r  <= CCW'(cs_r[0]) + CCW'(cs_r[1]) + CCW'(cs_r[2]);
      rd_r  <= rd6_r;
      ctl_r <= ctl6_r;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/voxel_capsule_domain_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_capsule_domain_classifier
// Decides per voxel whether it lies in one bone segment's capsule domain.
// ----------------------------------------------------------------------------
// Takes one voxel item per clock while in_tready is high and returns one
// in_domain item per voxel, in order; the 8-stage pipeline (difference,
// products, dot sums, magnitude, partial products, recombine, sum, decide)
// registers each step, and out_tready alone sets the rate. A stall is
// absorbed stage by stage, so empty stages still take new items. Label 0
// gives 0, a nonzero label equal to edge_label gives 1, and any other voxel
// is tested against the head sphere, the tail sphere and the cylinder
// between them with exact integer math. Write configuration only while no
// item is in flight.
// ----------------------------------------------------------------------------
module voxel_capsule_domain_classifier import vcdc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration write port
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_addr,
  input  logic [COORD_BITS-1:0]   cfg_wdata,
  // voxel items
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // voxel_label, pos_x, pos_y, pos_z (low to high), zero padded to bytes
  input  logic [((LABEL_BITS+3*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // result items
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // in_domain (bit 0), zero padded
  output logic [OUT_BITS-1:0]     out_tdata
);

  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int RRW = 2 * COORD_BITS - 2;
  localparam int CCW = 4 * COORD_BITS + 4;
  localparam int RDW = 4 * COORD_BITS;

  // configuration registers
  logic signed [COORD_BITS-1:0] head_r [3];
  logic signed [COORD_BITS-1:0] tail_r [3];
  logic [COORD_BITS-2:0]        radius_r;
  logic [EDGE_BITS-1:0]         edge_r;

  // pipeline control
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] en;

  // item fields
  logic [LABEL_BITS-1:0]        voxel_label;
  logic signed [COORD_BITS-1:0] pos [3];

  // stage payloads
  logic signed [DW-1:0] h1 [3];
  logic signed [DW-1:0] t1 [3];
  logic signed [DW-1:0] d1 [3];
  ctl_t                 ctl1;
  logic signed [PW-1:0] c3 [3];
  logic [PW-1:0]        dd3;
  logic [RRW-1:0]       rr3;
  ctl_t                 ctl3;
  logic [CCW-1:0]       cc7;
  logic [RDW-1:0]       rd7;
  ctl_t                 ctl7;
  logic                 dom_nxt;
  logic                 dom_r;

  assign voxel_label = in_tdata[LABEL_BITS-1:0];
  assign pos[0]      = in_tdata[LABEL_BITS +: COORD_BITS];
  assign pos[1]      = in_tdata[LABEL_BITS+COORD_BITS +: COORD_BITS];
  assign pos[2]      = in_tdata[LABEL_BITS+2*COORD_BITS +: COORD_BITS];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      radius_r <= '0;
      edge_r   <= EDGE_LABEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_HEAD_X:     head_r[0] <= cfg_wdata;
        REG_HEAD_Y:     head_r[1] <= cfg_wdata;
        REG_HEAD_Z:     head_r[2] <= cfg_wdata;
        REG_TAIL_X:     tail_r[0] <= cfg_wdata;
        REG_TAIL_Y:     tail_r[1] <= cfg_wdata;
        REG_TAIL_Z:     tail_r[2] <= cfg_wdata;
        REG_RADIUS:     radius_r  <= cfg_wdata[COORD_BITS-2:0];
        REG_EDGE_LABEL: edge_r    <= cfg_wdata[EDGE_BITS-1:0];
      endcase
    end
  end

  // a stage loads when it is empty or its item moves on
  always_comb begin
    en[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
    valid_nxt[0] = en[0] ? in_tvalid : valid_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_nxt[k] = en[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = valid_r[NUM_STAGES-1];
  assign out_tdata  = OUT_BITS'(dom_r);

  vcdc_diff #(
    .COORD_BITS (COORD_BITS)
  ) u_diff (
    .clk         (clk),
    .en          (en[0]),
    .voxel_label (voxel_label),
    .pos         (pos),
    .head        (head_r),
    .tail        (tail_r),
    .edge_label  (edge_r),
    .h_r         (h1),
    .t_r         (t1),
    .d_r         (d1),
    .ctl_r       (ctl1)
  );

  vcdc_dot #(
    .COORD_BITS (COORD_BITS)
  ) u_dot (
    .clk    (clk),
    .en     (en[2:1]),
    .h      (h1),
    .t      (t1),
    .d      (d1),
    .ctl    (ctl1),
    .radius (radius_r),
    .c_r    (c3),
    .dd_r   (dd3),
    .rr_r   (rr3),
    .ctl_r  (ctl3)
  );

  vcdc_cross #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk   (clk),
    .en    (en[6:3]),
    .c     (c3),
    .dd    (dd3),
    .rr    (rr3),
    .ctl   (ctl3),
    .cc_r  (cc7),
    .rd_r  (rd7),
    .ctl_r (ctl7)
  );

  // final decision
  always_comb begin
    if (ctl7.fixed) begin
      dom_nxt = ctl7.fixed_val;
    end else begin
      dom_nxt = ctl7.near || (ctl7.seg_ok && (cc7 <= CCW'(rd7)));
    end
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      dom_r <= dom_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vcdc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vcdc_checker
// Port-level checks for the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module vcdc_checker import vcdc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic [((LABEL_BITS+3*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OUT_BITS-1:0] out_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result item changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item shown right after reset");

  // a free-running output never backs up the input
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled with output ready");

  // background voxel comes out as outside after the pipeline latency
  a_background: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tdata[LABEL_BITS-1:0] == '0))
    ##1 out_tready ##1 out_tready ##1 out_tready ##1 out_tready
    ##1 out_tready ##1 out_tready ##1 out_tready
    |=> out_tvalid && !out_tdata[0])
    else $error("background voxel not reported outside");

endmodule

bind voxel_capsule_domain_classifier vcdc_checker #(
  .COORD_BITS (COORD_BITS)
) u_vcdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
